[src/rhrp_pkg.sv]
`default_nettype none

package rhrp_pkg;

    localparam int CAPACITY = 1024;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DROP  = 2'd2;

    localparam int PC_W = 5;

    typedef struct packed {
        logic       action;
        logic [7:0] data_in;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic [1:0] status;
    } t_out;

    typedef enum logic {
        PH_LOADING,
        PH_READING
    } t_phase;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_FIRST,
        PTR_SECOND,
        PTR_STEP
    } t_ptr_op;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_I,
        MEM_RD_J,
        MEM_WR_I,
        MEM_WR_J
    } t_mem_op;

    typedef enum logic [2:0] {
        STK_NONE,
        STK_ROOT,
        STK_POP,
        STK_RIGHT,
        STK_LEFT
    } t_stk_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_EMPTY,
        COND_SHORT,
        COND_SPAN
    } t_cond;

    typedef struct packed {
        t_ptr_op          ptr;
        t_mem_op          mem;
        logic             latch_tmp;
        t_stk_op          stk;
        logic             load_mid;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             done;
    } t_ctrl;

    typedef struct packed {
        logic empty;
        logic short_seg;
        logic span_done;
    } t_flags;

    localparam t_ctrl CTRL_NOP = '{
        ptr:       PTR_HOLD,
        mem:       MEM_NONE,
        latch_tmp: 1'b0,
        stk:       STK_NONE,
        load_mid:  1'b0,
        cond:      COND_NEXT,
        target:    '0,
        done:      1'b0
    };

    // program step addresses
    localparam logic [PC_W-1:0] ST_ROOT   = 5'd0;
    localparam logic [PC_W-1:0] ST_TEST   = 5'd1;
    localparam logic [PC_W-1:0] ST_POP    = 5'd2;
    localparam logic [PC_W-1:0] ST_CHECK  = 5'd3;
    localparam logic [PC_W-1:0] ST_A_INIT = 5'd4;
    localparam logic [PC_W-1:0] ST_A_CHK  = 5'd5;
    localparam logic [PC_W-1:0] ST_A_RDJ  = 5'd6;
    localparam logic [PC_W-1:0] ST_A_WRI  = 5'd7;
    localparam logic [PC_W-1:0] ST_A_WRJ  = 5'd8;
    localparam logic [PC_W-1:0] ST_B_INIT = 5'd9;
    localparam logic [PC_W-1:0] ST_B_CHK  = 5'd10;
    localparam logic [PC_W-1:0] ST_B_RDJ  = 5'd11;
    localparam logic [PC_W-1:0] ST_B_WRI  = 5'd12;
    localparam logic [PC_W-1:0] ST_B_WRJ  = 5'd13;
    localparam logic [PC_W-1:0] ST_PUSH_R = 5'd14;
    localparam logic [PC_W-1:0] ST_PUSH_L = 5'd15;
    localparam logic [PC_W-1:0] ST_DONE   = 5'd16;

    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (pc)
            ST_ROOT:   w.stk = STK_ROOT;
            ST_TEST: begin
                w.cond   = COND_EMPTY;
                w.target = ST_DONE;
            end
            ST_POP:    w.stk = STK_POP;
            ST_CHECK: begin
                w.load_mid = 1'b1;
                w.cond     = COND_SHORT;
                w.target   = ST_TEST;
            end
            ST_A_INIT: w.ptr = PTR_FIRST;
            ST_A_CHK: begin
                w.mem    = MEM_RD_I;
                w.cond   = COND_SPAN;
                w.target = ST_B_INIT;
            end
            ST_A_RDJ: begin
                w.mem       = MEM_RD_J;
                w.latch_tmp = 1'b1;
            end
            ST_A_WRI:  w.mem = MEM_WR_I;
            ST_A_WRJ: begin
                w.mem    = MEM_WR_J;
                w.ptr    = PTR_STEP;
                w.cond   = COND_ALWAYS;
                w.target = ST_A_CHK;
            end
            ST_B_INIT: w.ptr = PTR_SECOND;
            ST_B_CHK: begin
                w.mem    = MEM_RD_I;
                w.cond   = COND_SPAN;
                w.target = ST_PUSH_R;
            end
            ST_B_RDJ: begin
                w.mem       = MEM_RD_J;
                w.latch_tmp = 1'b1;
            end
            ST_B_WRI:  w.mem = MEM_WR_I;
            ST_B_WRJ: begin
                w.mem    = MEM_WR_J;
                w.ptr    = PTR_STEP;
                w.cond   = COND_ALWAYS;
                w.target = ST_B_CHK;
            end
            ST_PUSH_R: w.stk = STK_RIGHT;
            ST_PUSH_L: begin
                w.stk    = STK_LEFT;
                w.cond   = COND_ALWAYS;
                w.target = ST_TEST;
            end
            ST_DONE:   w.done = 1'b1;
            default:   w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/recursive_half_reversal_permuter.sv]
// load: one byte per cycle unless held off; an overflow result is registered the next cycle
// read: the byte goes to a pending register, then to the result; no new read while pending
// permutation after the last byte: segments longer than two bytes are split at the midpoint,
// both halves are reversed by byte swaps (two reads, two writes each) and pushed on a stack;
// input is held off while the permutation runs
// reset (synchronous, active low) empties the block; buffer contents stay undefined
`default_nettype none

module recursive_half_reversal_permuter #(
    parameter int CAPACITY = rhrp_pkg::CAPACITY
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rhrp_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output rhrp_pkg::t_out      o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    rhrp_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rp, n_rp;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    logic             r_out_valid, n_out_valid;
    rhrp_pkg::t_out   r_out, n_out;

    logic             w_busy;
    logic             w_accept;
    logic             w_start;
    logic [CW-1:0]    w_base;
    logic [CW-1:0]    w_rp_inc;
    logic             w_load_we;

    rhrp_pkg::t_ctrl  w_ctrl;
    rhrp_pkg::t_flags w_flags;
    logic             w_dp_we;
    logic [AW-1:0]    w_dp_addr;
    logic [7:0]       w_dp_wdata;

    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [7:0]       w_ram_wdata;
    logic [AW-1:0]    w_ram_raddr;
    logic [7:0]       w_ram_rdata;

    assign o_in_ready = !w_busy && !r_pend && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_base     = (r_phase == rhrp_pkg::PH_READING) ? '0 : r_count;
    assign w_rp_inc   = r_rp + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rhrp_pkg::PH_LOADING;
            r_count     <= '0;
            r_rp        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_rp        <= n_rp;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_rp        = r_rp;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_start     = 1'b0;
        w_load_we   = 1'b0;

        if (r_pend) begin
            n_out_valid     = 1'b1;
            n_out.data_out  = w_ram_rdata;
            n_out.last_out  = r_pend_last;
            n_out.status    = rhrp_pkg::STATUS_OK;
        end

        if (w_accept) begin
            if (!i_in_data.action) begin
                n_phase = rhrp_pkg::PH_LOADING;
                n_rp    = '0;
                if (w_base < CW'(CAPACITY)) begin
                    w_load_we = 1'b1;
                    n_count   = w_base + CW'(1);
                end else begin
                    n_count     = w_base;
                    n_out_valid = 1'b1;
                    n_out       = '{data_out: 8'd0, last_out: 1'b0,
                                    status: rhrp_pkg::STATUS_DROP};
                end
                if (i_in_data.last_in) begin
                    w_start = 1'b1;
                    n_phase = rhrp_pkg::PH_READING;
                end
            end else if (r_phase == rhrp_pkg::PH_READING && r_rp < r_count) begin
                // data comes out of the buffer next cycle
                n_pend      = 1'b1;
                n_pend_last = (w_rp_inc >= r_count);
                n_rp        = w_rp_inc;
                if (w_rp_inc >= r_count) begin
                    n_phase = rhrp_pkg::PH_LOADING;
                    n_count = '0;
                    n_rp    = '0;
                end
            end else begin
                if (r_phase == rhrp_pkg::PH_READING) begin
                    n_phase = rhrp_pkg::PH_LOADING;
                    n_count = '0;
                    n_rp    = '0;
                end
                n_out_valid = 1'b1;
                n_out       = '{data_out: 8'd0, last_out: 1'b0,
                                status: rhrp_pkg::STATUS_EMPTY};
            end
        end
    end

    assign w_ram_we    = w_busy ? w_dp_we    : w_load_we;
    assign w_ram_waddr = w_busy ? w_dp_addr  : w_base[AW-1:0];
    assign w_ram_wdata = w_busy ? w_dp_wdata : i_in_data.data_in;
    assign w_ram_raddr = w_busy ? w_dp_addr  : r_rp[AW-1:0];

    rhrp_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    rhrp_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_busy  (w_busy)
    );

    rhrp_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .i_rdata (w_ram_rdata),
        .o_flags (w_flags),
        .o_we    (w_dp_we),
        .o_addr  (w_dp_addr),
        .o_wdata (w_dp_wdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[src/rhrp_ram.sv]
`default_nettype none

module rhrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/rhrp_sequencer.sv]
`default_nettype none

module rhrp_sequencer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire rhrp_pkg::t_flags i_flags,
    output rhrp_pkg::t_ctrl       o_ctrl,
    output logic                  o_busy
);

    logic                      r_busy, n_busy;
    logic [rhrp_pkg::PC_W-1:0] r_pc, n_pc;
    rhrp_pkg::t_ctrl           w_word;
    logic                      w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        w_word = rhrp_pkg::rom_word(r_pc);
        unique case (w_word.cond)
            rhrp_pkg::COND_NEXT:   w_taken = 1'b0;
            rhrp_pkg::COND_ALWAYS: w_taken = 1'b1;
            rhrp_pkg::COND_EMPTY:  w_taken = i_flags.empty;
            rhrp_pkg::COND_SHORT:  w_taken = i_flags.short_seg;
            rhrp_pkg::COND_SPAN:   w_taken = i_flags.span_done;
            default:               w_taken = 1'b0;
        endcase

        n_busy = r_busy;
        n_pc   = r_pc;
        if (r_busy) begin
            n_pc = w_taken ? w_word.target : r_pc + 1'b1;
            if (w_word.done) begin
                n_busy = 1'b0;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_pc   = rhrp_pkg::ST_ROOT;
        end
    end

    assign o_ctrl = r_busy ? w_word : rhrp_pkg::CTRL_NOP;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

[src/rhrp_datapath.sv]
`default_nettype none

module rhrp_datapath #(
    parameter int CAPACITY = rhrp_pkg::CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rhrp_pkg::t_ctrl             i_ctrl,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  wire logic [7:0]                  i_rdata,
    output rhrp_pkg::t_flags                 o_flags,
    output logic                             o_we,
    output logic [$clog2(CAPACITY)-1:0]      o_addr,
    output logic [7:0]                       o_wdata
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    // one level per halving plus the pair pushed last
    localparam int SD  = $clog2(CAPACITY) + 2;
    localparam int SI  = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    logic [CW-1:0]  r_lo, r_hi, r_mid, r_i, r_j;
    logic [7:0]     r_tmp;
    logic [CW-1:0]  r_stk_lo [SD];
    logic [CW-1:0]  r_stk_hi [SD];
    logic [SPW-1:0] r_sp;

    logic [CW-1:0]  w_len;
    logic [CW-1:0]  w_jm1;
    logic [SPW-1:0] w_sp_dec;
    logic [SI-1:0]  w_top;
    logic [SI-1:0]  w_push;
    logic [CW:0]    w_i_inc;

    assign w_len    = r_hi - r_lo;
    assign w_jm1    = r_j - CW'(1);
    assign w_sp_dec = r_sp - SPW'(1);
    assign w_top    = w_sp_dec[SI-1:0];
    assign w_push   = r_sp[SI-1:0];
    assign w_i_inc  = {1'b0, r_i} + (CW+1)'(1);

    assign o_flags.empty     = (r_sp == '0);
    assign o_flags.short_seg = (w_len <= CW'(2));
    assign o_flags.span_done = (w_i_inc >= {1'b0, r_j});

    always_comb begin
        o_we    = 1'b0;
        o_addr  = r_i[AW-1:0];
        o_wdata = i_rdata;
        case (i_ctrl.mem)
            rhrp_pkg::MEM_RD_J: o_addr = w_jm1[AW-1:0];
            rhrp_pkg::MEM_WR_I: o_we = 1'b1;
            rhrp_pkg::MEM_WR_J: begin
                o_we    = 1'b1;
                o_addr  = w_jm1[AW-1:0];
                o_wdata = r_tmp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            case (i_ctrl.stk)
                rhrp_pkg::STK_ROOT:  r_sp <= SPW'(1);
                rhrp_pkg::STK_POP:   r_sp <= w_sp_dec;
                rhrp_pkg::STK_RIGHT,
                rhrp_pkg::STK_LEFT:  r_sp <= r_sp + SPW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.stk)
            rhrp_pkg::STK_ROOT: begin
                r_stk_lo[0] <= '0;
                r_stk_hi[0] <= i_count;
            end
            rhrp_pkg::STK_POP: begin
                r_lo <= r_stk_lo[w_top];
                r_hi <= r_stk_hi[w_top];
            end
            rhrp_pkg::STK_RIGHT: begin
                r_stk_lo[w_push] <= r_mid;
                r_stk_hi[w_push] <= r_hi;
            end
            rhrp_pkg::STK_LEFT: begin
                r_stk_lo[w_push] <= r_lo;
                r_stk_hi[w_push] <= r_mid;
            end
            default: ;
        endcase

        if (i_ctrl.load_mid) begin
            r_mid <= r_lo + (w_len >> 1);
        end

        if (i_ctrl.latch_tmp) begin
            r_tmp <= i_rdata;
        end

        case (i_ctrl.ptr)
            rhrp_pkg::PTR_FIRST: begin
                r_i <= r_lo;
                r_j <= r_mid;
            end
            rhrp_pkg::PTR_SECOND: begin
                r_i <= r_mid;
                r_j <= r_hi;
            end
            rhrp_pkg::PTR_STEP: begin
                r_i <= w_i_inc[CW-1:0];
                r_j <= w_jm1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
